@@ design/glyph_text_renderer_macros.svh @@
// assertion macros for the glyph text renderer
// expects clk and rst_n in the scope where a macro is used
`ifndef GLYPH_TEXT_RENDERER_MACROS_SVH
`define GLYPH_TEXT_RENDERER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GTR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTR_ASSERT_SAME(lbl, ante, cons, msg)
`define GTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/gtr_pkg.sv @@
// shared types and constants of the glyph text renderer
// no dependencies
package gtr_pkg;

  localparam int GlyphDim = 8;
  localparam logic [6:0] NewlineCode = 7'd10;

  localparam logic [31:0] FrameBaseReset = 32'h0000_0000;
  localparam logic [15:0] LinePitchReset = 16'd4096;
  localparam logic [31:0] TextColorReset = 32'h00FF_FFFF;

  localparam logic [1:0] CfgFrameBase = 2'd0;
  localparam logic [1:0] CfgLinePitch = 2'd1;
  localparam logic [1:0] CfgTextColor = 2'd2;

  // commands from the sequencer to the pixel scanner
  typedef struct packed {
    logic       start;
    logic       row_vld;
    logic [7:0] row_bits;
  } gtr_scan_cmd_t;

endpackage

@@ design/glyph_text_renderer.sv @@
// glyph text renderer top level: input sequencer, cursor and registers
// uses gtr_pkg, gtr_glyph_mem, gtr_serial_mul and gtr_pixel_scan
// Input channel (in_valid / in_stall) takes one word per item: a glyph
// row load (func 0) or a character print (func 1). Output channel
// (out_valid / out_stall) gives one pixel write per set glyph bit, with
// out_last_pixel on the final write of a character. cfg_valid / cfg_ready
// writes frame_base (0), line_pitch (1) or text_color (2); cfg_ready is
// always high and other indexes are dropped.
// A load or a newline is accepted in the idle state and leaves the
// sequencer idle. A printed character is accepted, then in the fetch
// state the bit-serial multiplier forms frame_base + row * pitch one
// cursor bit a cycle while the eight glyph rows are read from the
// store; a setup state follows, then the scan takes one glyph bit per
// cycle, while the receiver does not stall, up to the last set bit
// (at most 64 bits). Each pixel word is registered from the scan step
// of its bit. A blank glyph still goes through the fetch and a scan step.
// in_stall is high from acceptance of a print item until its scan ends.
// When the receiver stalls, the held word stays and the scan waits.
// Reset clears the cursor, the registers and both channels; the glyph
// store is not cleared and needs no clearing pass.
module glyph_text_renderer #(
  parameter int GLYPH_COUNT = 128,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [6:0]  in_char_code,
  input  logic [2:0]  in_glyph_row,
  input  logic [7:0]  in_row_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_address,
  output logic [31:0] out_pixel_value,
  output logic        out_last_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import gtr_pkg::*;

  localparam int AddrBits    = $clog2(GLYPH_COUNT * 8);
  localparam int FetchCycles = (COORD_BITS > 9) ? COORD_BITS : 9;
  localparam int FetchBits   = $clog2(FetchCycles);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StSetup = 2'd2;
  localparam logic [1:0] StScan  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [FetchBits-1:0]  cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [31:0]           frame_base_r, frame_base_nxt;
  logic [15:0]           line_pitch_r, line_pitch_nxt;
  logic [31:0]           text_color_r, text_color_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [6:0]            code_r, code_nxt;
  logic                  code_ok_r, code_ok_nxt;
  logic [31:0]           job_base_r, job_base_nxt;
  logic [15:0]           job_pitch_r, job_pitch_nxt;
  logic [31:0]           job_color_r, job_color_nxt;
  logic [COORD_BITS-1:0] job_col_r, job_col_nxt;
  logic [COORD_BITS-1:0] job_row_r, job_row_nxt;

  logic                  in_acc;
  logic                  code_in_range;
  logic                  print_go;
  logic                  mem_we;
  logic                  mem_re;
  logic [AddrBits-1:0]   mem_waddr;
  logic [AddrBits-1:0]   mem_raddr;
  logic [7:0]            mem_rdata;
  logic [31:0]           mul_acc;
  logic                  scan_done;
  gtr_scan_cmd_t         scan_cmd;

  assign in_stall      = (state_r != StIdle);
  assign cfg_ready     = 1'b1;
  assign in_acc        = in_valid && !in_stall;
  assign code_in_range = (32'(in_char_code) < GLYPH_COUNT);
  assign print_go      = in_acc && in_func && (in_char_code != NewlineCode);
  assign mem_we        = in_acc && !in_func && code_in_range;
  assign mem_waddr     = AddrBits'({in_char_code, in_glyph_row});
  assign mem_re        = (state_r == StFetch) && (cnt_r < FetchBits'(GlyphDim));
  assign mem_raddr     = AddrBits'({code_r, cnt_r[2:0]});

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    frame_base_nxt = frame_base_r;
    line_pitch_nxt = line_pitch_r;
    text_color_nxt = text_color_r;
    rd_vld_nxt     = mem_re;
    code_nxt       = code_r;
    code_ok_nxt    = code_ok_r;
    job_base_nxt   = job_base_r;
    job_pitch_nxt  = job_pitch_r;
    job_color_nxt  = job_color_r;
    job_col_nxt    = job_col_r;
    job_row_nxt    = job_row_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CfgFrameBase: frame_base_nxt = cfg_data;
        CfgLinePitch: line_pitch_nxt = cfg_data[15:0];
        CfgTextColor: text_color_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      StIdle: begin
        if (in_acc && in_func) begin
          if (in_char_code == NewlineCode) begin
            cur_col_nxt = '0;
            cur_row_nxt = cur_row_r + COORD_BITS'(GlyphDim);
          end else begin
            cur_col_nxt   = cur_col_r + COORD_BITS'(GlyphDim);
            code_nxt      = in_char_code;
            code_ok_nxt   = code_in_range;
            job_base_nxt  = frame_base_r;
            job_pitch_nxt = line_pitch_r;
            job_color_nxt = text_color_r;
            job_col_nxt   = cur_col_r;
            job_row_nxt   = cur_row_r;
            cnt_nxt       = '0;
            state_nxt     = StFetch;
          end
        end
      end
      StFetch: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == FetchBits'(FetchCycles - 1)) begin
          state_nxt = StSetup;
        end
      end
      StSetup: begin
        state_nxt = StScan;
      end
      StScan: begin
        if (scan_done) begin
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StIdle;
      cnt_r        <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      frame_base_r <= FrameBaseReset;
      line_pitch_r <= LinePitchReset;
      text_color_r <= TextColorReset;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      frame_base_r <= frame_base_nxt;
      line_pitch_r <= line_pitch_nxt;
      text_color_r <= text_color_nxt;
      rd_vld_r     <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    code_ok_r   <= code_ok_nxt;
    job_base_r  <= job_base_nxt;
    job_pitch_r <= job_pitch_nxt;
    job_color_r <= job_color_nxt;
    job_col_r   <= job_col_nxt;
    job_row_r   <= job_row_nxt;
  end

  // codes past the store draw a blank glyph
  assign scan_cmd.start    = (state_r == StSetup);
  assign scan_cmd.row_vld  = rd_vld_r;
  assign scan_cmd.row_bits = code_ok_r ? mem_rdata : 8'h00;

  gtr_glyph_mem #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .ADDR_BITS   (AddrBits)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_row_bits),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gtr_serial_mul #(
    .COORD_BITS (COORD_BITS)
  ) u_mul (
    .clk    (clk),
    .load   (print_go),
    .step   (state_r == StFetch),
    .base   (frame_base_r),
    .mcand  (line_pitch_r),
    .mplier (cur_row_r),
    .acc    (mul_acc)
  );

  gtr_pixel_scan #(
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (scan_cmd),
    .row_base          (mul_acc),
    .frame_base        (job_base_r),
    .line_pitch        (job_pitch_r),
    .text_color        (job_color_r),
    .start_col         (job_col_r),
    .start_row         (job_row_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_last_pixel    (out_last_pixel),
    .done              (scan_done)
  );

endmodule

@@ design/gtr_glyph_mem.sv @@
// glyph store: one 8-bit bitmap row per entry, registered read
// depends on nothing; addressed as {char code, glyph row}
module gtr_glyph_mem #(
  parameter int GLYPH_COUNT = 128,
  parameter int ADDR_BITS   = $clog2(GLYPH_COUNT * 8)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [7:0]           wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [7:0]           rdata
);

  logic [7:0] mem [GLYPH_COUNT*8];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/gtr_serial_mul.sv @@
// bit-serial multiply-accumulate: acc = base + mplier * mcand
// one multiplier bit per step, lsb first; no dependencies
module gtr_serial_mul #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [31:0]           base,
  input  logic [15:0]           mcand,
  input  logic [COORD_BITS-1:0] mplier,
  output logic [31:0]           acc
);

  logic [31:0]           acc_r, acc_nxt;
  logic [31:0]           mcand_r, mcand_nxt;
  logic [COORD_BITS-1:0] mplier_r, mplier_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (load) begin
      acc_nxt    = base;
      mcand_nxt  = 32'(mcand);
      mplier_nxt = mplier;
    end else if (step) begin
      // once the multiplier bits run out the partial product is zero
      acc_nxt    = acc_r + (mplier_r[0] ? mcand_r : 32'd0);
      mcand_nxt  = {mcand_r[30:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[COORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign acc = acc_r;

endmodule

@@ design/gtr_pixel_scan.sv @@
// pixel scanner: 64-bit glyph shift register (one bit per cycle unless
// stalled), pixel addresses and the output word register; uses gtr_pkg
`include "glyph_text_renderer_macros.svh"
module gtr_pixel_scan #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gtr_pkg::gtr_scan_cmd_t cmd,
  input  logic [31:0]           row_base,
  input  logic [31:0]           frame_base,
  input  logic [15:0]           line_pitch,
  input  logic [31:0]           text_color,
  input  logic [COORD_BITS-1:0] start_col,
  input  logic [COORD_BITS-1:0] start_row,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [31:0]           out_pixel_address,
  output logic [31:0]           out_pixel_value,
  output logic                  out_last_pixel,
  output logic                  done
);

  import gtr_pkg::*;

  logic                  active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           glyph_r, glyph_nxt;
  logic [2:0]            col_r, col_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;
  logic [COORD_BITS-1:0] col0_r, col0_nxt;
  logic [31:0]           row_base_r, row_base_nxt;
  logic [31:0]           base_r, base_nxt;
  logic [15:0]           pitch_r, pitch_nxt;
  logic [31:0]           color_r, color_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [31:0]           value_r, value_nxt;
  logic                  last_r, last_nxt;
  logic                  slot_free;
  logic                  step;
  logic                  rest_clear;

  assign slot_free  = !out_valid_r || !out_stall;
  assign step       = active_r && slot_free;
  assign rest_clear = (glyph_r[62:0] == 63'd0);

  always_comb begin
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    col0_nxt      = col0_r;
    row_base_nxt  = row_base_r;
    base_nxt      = base_r;
    pitch_nxt     = pitch_r;
    color_nxt     = color_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    last_nxt      = last_r;

    if (slot_free) begin
      out_valid_nxt = active_r && glyph_r[63];
    end

    if (cmd.row_vld) begin
      glyph_nxt = {glyph_r[55:0], cmd.row_bits};
    end

    if (cmd.start) begin
      active_nxt   = 1'b1;
      col_nxt      = 3'd0;
      px_nxt       = start_col;
      py_nxt       = start_row;
      col0_nxt     = start_col;
      row_base_nxt = row_base;
      base_nxt     = frame_base;
      pitch_nxt    = line_pitch;
      color_nxt    = text_color;
    end else if (step) begin
      glyph_nxt = {glyph_r[62:0], 1'b0};
      if (glyph_r[63]) begin
        addr_nxt  = row_base_r + 32'({px_r, 2'b00});
        value_nxt = color_r;
        last_nxt  = rest_clear;
      end
      col_nxt = col_r + 3'd1;
      px_nxt  = px_r + 1'b1;
      if (col_r == 3'(GlyphDim - 1)) begin
        px_nxt = col0_r;
        py_nxt = py_r + 1'b1;
        // row coordinate wraps to zero, so the row offset does too
        row_base_nxt = (py_r == '1) ? base_r : row_base_r + 32'(pitch_r);
      end
      // no set bits left: the character is finished
      if (rest_clear) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r    <= glyph_nxt;
    col_r      <= col_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    col0_r     <= col0_nxt;
    row_base_r <= row_base_nxt;
    base_r     <= base_nxt;
    pitch_r    <= pitch_nxt;
    color_r    <= color_nxt;
    addr_r     <= addr_nxt;
    value_r    <= value_nxt;
    last_r     <= last_nxt;
  end

  assign done              = step && rest_clear;
  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = value_r;
  assign out_last_pixel    = last_r;

  `GTR_ASSERT_NEXT(a_last_ends_scan, step && glyph_r[63] && rest_clear, !active_r, "scan overran")
  `GTR_ASSERT_SAME(a_no_start_busy, cmd.start, !active_r, "scan started while busy")
  `GTR_ASSERT_SAME(a_no_fill_busy, cmd.row_vld, !active_r, "glyph row loaded during scan")

endmodule
